// ----- sv/euler_rusanov_flux_1d_top_assert.svh -----
// Assertion macros shared by the Rusanov flux block.
`ifndef EULER_RUSANOV_FLUX_1D_TOP_ASSERT_SVH
`define EULER_RUSANOV_FLUX_1D_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ERF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ERF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ERF_ASSERT(lbl, prop, msg)
`define ERF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/erf_pkg.sv -----
// Package with types, defaults and saturating helpers of the Rusanov flux block.
package erf_pkg;

  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int AccWidth     = 65;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_RHO = 2'd1,
    ST_BAD_C2  = 2'd2
  } erf_status_e;

  typedef logic signed [AccWidth-1:0] acc_t;

  function automatic acc_t sat_fit(acc_t v, int unsigned w);
    acc_t hi;
    acc_t lo;
    hi = (acc_t'(1) <<< (w - 1)) - acc_t'(1);
    lo = -hi - acc_t'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic acc_t sat_add(acc_t a, acc_t b, int unsigned w);
    return sat_fit(a + b, w);
  endfunction

  function automatic acc_t sat_sub(acc_t a, acc_t b, int unsigned w);
    return sat_fit(a - b, w);
  endfunction

endpackage

// ----- sv/erf_delay.sv -----
// Shift-register delay line that advances on the pipeline enable.
module erf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        line_q[i] <= '0;
      end
    end else if (adv_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

// ----- sv/erf_qmul.sv -----
// Registered saturating fixed-point multiplier, truncating toward zero.
module erf_qmul #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  output logic signed [DW-1:0] p_o
);

  localparam int PW = 2 * DW;
  localparam logic [PW-1:0] LimPos = (PW'(1) << (DW - 1)) - PW'(1);
  localparam logic [PW-1:0] LimNeg = PW'(1) << (DW - 1);

  logic [DW-1:0] ma, mb;
  logic [PW-1:0] prod, sh;
  logic neg;
  logic signed [DW-1:0] p_d, p_q;

  assign ma = a_i[DW-1] ? (~a_i + 1'b1) : a_i;
  assign mb = b_i[DW-1] ? (~b_i + 1'b1) : b_i;
  assign prod = PW'(ma) * PW'(mb);
  assign sh = prod >> FB;
  assign neg = a_i[DW-1] ^ b_i[DW-1];

  always_comb begin
    if (neg) begin
      p_d = (sh > LimNeg) ? {1'b1, {(DW-1){1'b0}}} : (~sh[DW-1:0] + 1'b1);
    end else begin
      p_d = (sh > LimPos) ? {1'b0, {(DW-1){1'b1}}} : sh[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- sv/erf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturated signed result.
module erf_div #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic signed [DW-1:0] a_i,
  input  logic        [DW-1:0] d_i,
  output logic signed [DW-1:0] q_o
);

  localparam int N = DW + FB;
  localparam logic [N-1:0] LimPos = (N'(1) << (DW - 1)) - N'(1);
  localparam logic [N-1:0] LimNeg = N'(1) << (DW - 1);

  logic [DW-1:0] ma;
  logic [N-1:0]  num [N];
  logic [DW-2:0] rem [N];
  logic [DW-2:0] den [N];
  logic [N-1:0]  quo [N+1];
  logic          neg [N+1];
  logic signed [DW-1:0] q_d, q_q;

  assign ma = a_i[DW-1] ? (~a_i + 1'b1) : a_i;
  assign num[0] = {ma, {FB{1'b0}}};
  assign rem[0] = '0;
  assign den[0] = d_i[DW-2:0];
  assign quo[0] = '0;
  assign neg[0] = a_i[DW-1];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [DW-1:0] trial;
    logic take;
    assign trial = {rem[s], num[s][N-1]};
    assign take = trial >= {1'b0, den[s]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quo[s+1] <= {quo[s][N-2:0], take};
        neg[s+1] <= neg[s];
      end
    end
    if (s < N - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          num[s+1] <= num[s] << 1;
          rem[s+1] <= take ? (DW-1)'(trial - {1'b0, den[s]}) : trial[DW-2:0];
          den[s+1] <= den[s];
        end
      end
    end
  end

  always_comb begin
    if (neg[N]) begin
      q_d = (quo[N] > LimNeg) ? {1'b1, {(DW-1){1'b0}}} : (~quo[N][DW-1:0] + 1'b1);
    end else begin
      q_d = (quo[N] > LimPos) ? {1'b0, {(DW-1){1'b1}}} : quo[N][DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ----- sv/erf_sqrt.sv -----
// Pipelined digit-by-digit integer square root of c2 scaled by the fraction bits.
module erf_sqrt #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [DW-1:0]                 c_i,
  output logic [(DW + FB) / 2 - 1:0]    root_o
);

  localparam int RB = (DW + FB) / 2;
  localparam int NB = 2 * RB;

  logic [NB-1:0] num  [RB];
  logic [RB+1:0] rem  [RB];
  logic [RB-1:0] root [RB+1];

  assign num[0]  = NB'({c_i, {FB{1'b0}}});
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar s = 0; s < RB; s++) begin : g_stage
    logic [RB+3:0] trial, tst;
    logic take;
    assign trial = {rem[s], num[s][NB-1 -: 2]};
    assign tst = {2'b00, root[s], 2'b01};
    assign take = trial >= tst;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        root[s+1] <= {root[s][RB-2:0], take};
      end
    end
    if (s < RB - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          num[s+1] <= num[s] << 2;
          rem[s+1] <= take ? (RB+2)'(trial - tst) : trial[RB+1:0];
        end
      end
    end
  end

  assign root_o = root[RB];

endmodule

// ----- sv/erf_side.sv -----
// Per-side pipeline: velocity, physical flux, sound speed and largest wave speed.
module erf_side #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic signed [DW-1:0] rho_i,
  input  logic signed [DW-1:0] mom_i,
  input  logic signed [DW-1:0] energy_i,
  output logic signed [DW-1:0] speed_o,
  output logic signed [DW-1:0] flux_mom_o,
  output logic signed [DW-1:0] flux_en_o,
  output logic                 c2_ok_o
);
  import erf_pkg::*;

  localparam int N  = DW + FB;
  localparam int RB = (DW + FB) / 2;
  localparam logic signed [DW-1:0] CGam  = DW'(((64'd7 << FB) + 64'd2) / 64'd5);
  localparam logic signed [DW-1:0] CGm1  = DW'(((64'd2 << FB) + 64'd2) / 64'd5);
  localparam logic signed [DW-1:0] CGgm1 = DW'(((64'd14 << FB) + 64'd12) / 64'd25);
  localparam logic signed [DW-1:0] CK08  = DW'(((64'd4 << FB) + 64'd2) / 64'd5);
  localparam logic signed [DW-1:0] CK02  = DW'(((64'd1 << FB) + 64'd2) / 64'd5);
  localparam logic signed [DW-1:0] CHalf = DW'(((64'd1 << FB) + 64'd1) / 64'd2);
  localparam logic signed [DW-1:0] VMax  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMin  = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] u1, e1, mom1, en1;
  logic signed [DW-1:0] uu2, um2, ue2, ge2;
  logic signed [DW-1:0] u2_q, e2_q, mom2_q;
  logic signed [DW-1:0] huu3, k08um3, gue3, uum3;
  logic signed [DW-1:0] u3_q, e3_q, ge3_q;
  logic signed [DW-1:0] d4_d, d4_q, f1_4_d, f1_4_q, au4_d, au4_q, gue4_q, k02uum4;
  logic signed [DW-1:0] c2_5, f2_5_d, f2_5_q, f1_5_q, au5_q;
  logic                 ok5;
  logic [DW-1:0]        sq_in;
  logic [RB-1:0]        root;
  logic [3*DW:0]        dly_d, dly_q;
  logic signed [DW-1:0] au7, f1_7, f2_7;
  logic                 ok7;
  acc_t                 root_s;
  logic signed [DW-1:0] speed_d, speed_q, f1_q, f2_q;
  logic                 ok_q;
  logic [2*DW-1:0]      in_dly;

  erf_div #(.DW(DW), .FB(FB)) u_div_u (
    .clk_i, .adv_i, .a_i(mom_i), .d_i(rho_i), .q_o(u1)
  );
  erf_div #(.DW(DW), .FB(FB)) u_div_e (
    .clk_i, .adv_i, .a_i(energy_i), .d_i(rho_i), .q_o(e1)
  );
  erf_delay #(.WIDTH(2*DW), .DEPTH(N + 1)) u_dly_in (
    .clk_i, .rst_ni, .adv_i, .d_i({energy_i, mom_i}), .q_o(in_dly)
  );
  assign mom1 = in_dly[DW-1:0];
  assign en1  = in_dly[2*DW-1:DW];

  erf_qmul #(.DW(DW), .FB(FB)) u_m_uu (.clk_i, .adv_i, .a_i(u1), .b_i(u1), .p_o(uu2));
  erf_qmul #(.DW(DW), .FB(FB)) u_m_um (.clk_i, .adv_i, .a_i(u1), .b_i(mom1), .p_o(um2));
  erf_qmul #(.DW(DW), .FB(FB)) u_m_ue (.clk_i, .adv_i, .a_i(u1), .b_i(en1), .p_o(ue2));
  erf_qmul #(.DW(DW), .FB(FB)) u_m_ge (.clk_i, .adv_i, .a_i(CGm1), .b_i(en1), .p_o(ge2));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u2_q   <= u1;
      e2_q   <= e1;
      mom2_q <= mom1;
    end
  end

  erf_qmul #(.DW(DW), .FB(FB)) u_m_huu (.clk_i, .adv_i, .a_i(CHalf), .b_i(uu2), .p_o(huu3));
  erf_qmul #(.DW(DW), .FB(FB)) u_m_k08 (.clk_i, .adv_i, .a_i(CK08), .b_i(um2), .p_o(k08um3));
  erf_qmul #(.DW(DW), .FB(FB)) u_m_gue (.clk_i, .adv_i, .a_i(CGam), .b_i(ue2), .p_o(gue3));
  erf_qmul #(.DW(DW), .FB(FB)) u_m_uum (.clk_i, .adv_i, .a_i(uu2), .b_i(mom2_q), .p_o(uum3));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u3_q  <= u2_q;
      e3_q  <= e2_q;
      ge3_q <= ge2;
    end
  end

  assign d4_d   = DW'(sat_sub(acc_t'(e3_q), acc_t'(huu3), DW));
  assign f1_4_d = DW'(sat_add(acc_t'(k08um3), acc_t'(ge3_q), DW));
  assign au4_d  = u3_q[DW-1] ? ((u3_q == VMin) ? VMax : -u3_q) : u3_q;

  erf_qmul #(.DW(DW), .FB(FB)) u_m_k02 (.clk_i, .adv_i, .a_i(CK02), .b_i(uum3), .p_o(k02uum4));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d4_q   <= d4_d;
      f1_4_q <= f1_4_d;
      au4_q  <= au4_d;
      gue4_q <= gue3;
    end
  end

  erf_qmul #(.DW(DW), .FB(FB)) u_m_c2 (.clk_i, .adv_i, .a_i(CGgm1), .b_i(d4_q), .p_o(c2_5));

  assign f2_5_d = DW'(sat_sub(acc_t'(gue4_q), acc_t'(k02uum4), DW));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f2_5_q <= f2_5_d;
      f1_5_q <= f1_4_q;
      au5_q  <= au4_q;
    end
  end

  assign ok5   = c2_5 > 0;
  assign sq_in = ok5 ? c2_5 : '0;

  erf_sqrt #(.DW(DW), .FB(FB)) u_sqrt (.clk_i, .adv_i, .c_i(sq_in), .root_o(root));

  assign dly_d = {ok5, f2_5_q, f1_5_q, au5_q};
  erf_delay #(.WIDTH(3*DW + 1), .DEPTH(RB)) u_dly_sq (
    .clk_i, .rst_ni, .adv_i, .d_i(dly_d), .q_o(dly_q)
  );
  assign au7 = dly_q[DW-1:0];
  assign f1_7 = dly_q[2*DW-1:DW];
  assign f2_7 = dly_q[3*DW-1:2*DW];
  assign ok7 = dly_q[3*DW];

  always_comb begin
    root_s = acc_t'(root);
    if (root_s > acc_t'(VMax)) begin
      root_s = acc_t'(VMax);
    end
    speed_d = ok7 ? DW'(sat_add(acc_t'(au7), root_s, DW)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      speed_q <= speed_d;
      f1_q    <= f1_7;
      f2_q    <= f2_7;
      ok_q    <= ok7;
    end
  end

  assign speed_o    = speed_q;
  assign flux_mom_o = f1_q;
  assign flux_en_o  = f2_q;
  assign c2_ok_o    = ok_q;

endmodule

// ----- sv/euler_rusanov_flux_1d_top.sv -----
// Rusanov numerical flux for one face of the 1D Euler equations, top level.
// Latency is set mainly by the one-bit-per-stage divider and the
// two-bit-per-stage square root.
// Throughput is one word per cycle; the whole pipeline halts while an output word waits.
// Reset clears all valid bits, the status pipeline and the delay lines; other data
// registers are not reset.
`include "euler_rusanov_flux_1d_top_assert.svh"

module euler_rusanov_flux_1d_top #(
  parameter int DATA_WIDTH = erf_pkg::DataWidthDef,
  parameter int FRAC_BITS  = erf_pkg::FracBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // left_density, left_momentum, left_energy, right_density, right_momentum,
  // right_energy
  input  logic [((6*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // mass_flux, momentum_flux, energy_flux
  output logic [((3*DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // status
  output logic [1:0]                              m_axis_tuser
);
  import erf_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int OW = ((3*DW + 7) / 8) * 8;
  localparam int LatSide = DW + FB + (DW + FB) / 2 + 6;
  localparam logic signed [DW-1:0] CHalf = DW'(((64'd1 << FB) + 64'd1) / 64'd2);

  logic adv;
  logic signed [DW-1:0] ql [3];
  logic signed [DW-1:0] qr [3];
  logic bad_in;
  logic signed [DW-1:0] rho_l, rho_r;
  logic [6*DW:0] dl_d, dl_q;
  logic vs;
  logic signed [DW-1:0] ql_d [3];
  logic signed [DW-1:0] qr_d [3];
  logic bad_d;
  logic signed [DW-1:0] sa, sb;
  logic signed [DW-1:0] fla [3];
  logic signed [DW-1:0] flb [3];
  logic oka, okb;

  logic v1_q, v2_q, v3_q, v4_q;
  erf_status_e st1_d, st1_q, st2_q, st3_q, st4_q;
  logic signed [DW-1:0] smax_q;
  logic signed [DW-1:0] dq1_q [3];
  logic signed [DW-1:0] ha [3];
  logic signed [DW-1:0] hb [3];
  logic signed [DW-1:0] hs;
  logic signed [DW-1:0] avg2_q [3];
  logic signed [DW-1:0] dq2_q [3];
  logic signed [DW-1:0] pr [3];
  logic signed [DW-1:0] avg3_q [3];
  logic signed [DW-1:0] out_d [3];
  logic signed [DW-1:0] out_q [3];

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ql[k] = s_axis_tdata[k*DW +: DW];
      qr[k] = s_axis_tdata[(k+3)*DW +: DW];
      ql_d[k] = dl_q[k*DW +: DW];
      qr_d[k] = dl_q[(k+3)*DW +: DW];
    end
  end

  assign bad_in = (ql[0] <= 0) || (qr[0] <= 0);
  assign rho_l = bad_in ? DW'(1) : ql[0];
  assign rho_r = bad_in ? DW'(1) : qr[0];

  erf_side #(.DW(DW), .FB(FB)) u_side_l (
    .clk_i, .rst_ni, .adv_i(adv), .rho_i(rho_l), .mom_i(ql[1]), .energy_i(ql[2]),
    .speed_o(sa), .flux_mom_o(fla[1]), .flux_en_o(fla[2]), .c2_ok_o(oka)
  );
  erf_side #(.DW(DW), .FB(FB)) u_side_r (
    .clk_i, .rst_ni, .adv_i(adv), .rho_i(rho_r), .mom_i(qr[1]), .energy_i(qr[2]),
    .speed_o(sb), .flux_mom_o(flb[1]), .flux_en_o(flb[2]), .c2_ok_o(okb)
  );

  assign dl_d = {bad_in, s_axis_tdata[6*DW-1:0]};
  erf_delay #(.WIDTH(6*DW + 1), .DEPTH(LatSide)) u_dly_q (
    .clk_i, .rst_ni, .adv_i(adv), .d_i(dl_d), .q_o(dl_q)
  );
  erf_delay #(.WIDTH(1), .DEPTH(LatSide)) u_dly_v (
    .clk_i, .rst_ni, .adv_i(adv), .d_i(s_axis_tvalid), .q_o(vs)
  );
  assign bad_d = dl_q[6*DW];
  assign fla[0] = ql_d[1];
  assign flb[0] = qr_d[1];

  always_comb begin
    if (bad_d) begin
      st1_d = ST_BAD_RHO;
    end else if (!oka || !okb) begin
      st1_d = ST_BAD_C2;
    end else begin
      st1_d = ST_OK;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    erf_qmul #(.DW(DW), .FB(FB)) u_m_ha (
      .clk_i, .adv_i(adv), .a_i(CHalf), .b_i(fla[k]), .p_o(ha[k])
    );
    erf_qmul #(.DW(DW), .FB(FB)) u_m_hb (
      .clk_i, .adv_i(adv), .a_i(CHalf), .b_i(flb[k]), .p_o(hb[k])
    );
    erf_qmul #(.DW(DW), .FB(FB)) u_m_p (
      .clk_i, .adv_i(adv), .a_i(hs), .b_i(dq2_q[k]), .p_o(pr[k])
    );
    assign out_d[k] = (st3_q == ST_OK) ?
                      DW'(sat_sub(acc_t'(avg3_q[k]), acc_t'(pr[k]), DW)) : '0;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dq1_q[k]  <= DW'(sat_sub(acc_t'(qr_d[k]), acc_t'(ql_d[k]), DW));
        avg2_q[k] <= DW'(sat_add(acc_t'(ha[k]), acc_t'(hb[k]), DW));
        dq2_q[k]  <= dq1_q[k];
        avg3_q[k] <= avg2_q[k];
        out_q[k]  <= out_d[k];
      end
    end
  end

  erf_qmul #(.DW(DW), .FB(FB)) u_m_hs (
    .clk_i, .adv_i(adv), .a_i(CHalf), .b_i(smax_q), .p_o(hs)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smax_q <= (sa > sb) ? sa : sb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      st1_q <= ST_OK;
      st2_q <= ST_OK;
      st3_q <= ST_OK;
      st4_q <= ST_OK;
    end else if (adv) begin
      v1_q  <= vs;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      st1_q <= st1_d;
      st2_q <= st1_q;
      st3_q <= st2_q;
      st4_q <= st3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = OW'({out_q[2], out_q[1], out_q[0]});
  assign m_axis_tuser  = st4_q;

  `ERF_ASSERT(a_speed_nonneg, v1_q && st1_q == ST_OK |-> !smax_q[DW-1], "negative wave speed")
  `ERF_ASSERT(a_err_zero, m_axis_tvalid && st4_q != ST_OK |-> m_axis_tdata == '0, "nonzero flux")
  `ERF_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `ERF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "output word valid in reset")

endmodule

// ----- tb/tb_euler_rusanov_flux_1d_top.sv -----
// Self-checking testbench for the Rusanov flux block: directed table, then random faces.
module tb_euler_rusanov_flux_1d_top;
  import erf_pkg::*;

  localparam int  DW       = 32;
  localparam int  FB       = 16;
  localparam int  NRAND    = 1630;
  localparam int  WDOG_MAX = 4000;
  localparam longint VMAX  = 64'sd2147483647;
  localparam longint VMIN  = -64'sd2147483648;
  localparam longint ONE   = 64'sd65536;

  typedef logic signed [DW-1:0] fix_t;
  typedef struct {
    fix_t        flux[3];
    erf_status_e status;
  } face_flux_t;
  typedef struct {
    fix_t        q[6];
    bit          typed;
    erf_status_e status;
  } face_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  face_flux_t flux_q[$];
  face_row_t  rows[$];
  int         fails = 0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         quiet = 0;

  always #4 clk_i = ~clk_i;

  euler_rusanov_flux_1d_top DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  function automatic longint mag(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint clamp(bit neg, longint m);
    if (neg) return m > VMAX + 1 ? VMIN : -m;
    return m > VMAX ? VMAX : m;
  endfunction

  function automatic longint sat(longint v);
    return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp((a < 0) != (b < 0), (mag(a) * mag(b)) >>> FB);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    return clamp(a < 0, (mag(a) <<< FB) / b);
  endfunction

  function automatic longint qsqrt(longint a);
    longint n;
    longint lo;
    longint hi;
    longint mid;
    n  = a <<< FB;
    lo = 0;
    hi = 64'sd1 <<< 24;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (mid * mid <= n) lo = mid; else hi = mid;
    end
    return lo > VMAX ? VMAX : lo;
  endfunction

  function automatic longint qconst(int n, int d);
    return ((longint'(n) <<< FB) + d / 2) / d;
  endfunction

  // Wave speed and physical flux of one side; returns 0 when c^2 is not positive.
  function automatic bit side_eval(longint rho, longint mom, longint en,
                                   output longint speed, output longint fl[3]);
    longint u;
    longint e;
    longint uu;
    longint c2;
    longint au;
    u  = qdiv(mom, rho);
    e  = qdiv(en, rho);
    uu = qmul(u, u);
    c2 = qmul(qconst(14, 25), sat(e - qmul(qconst(1, 2), uu)));
    au = u < 0 ? (u == VMIN ? VMAX : -u) : u;
    speed = c2 > 0 ? sat(au + qsqrt(c2)) : 0;
    fl[0] = mom;
    fl[1] = sat(qmul(qconst(4, 5), qmul(u, mom)) + qmul(qconst(2, 5), en));
    fl[2] = sat(qmul(qconst(7, 5), qmul(u, en)) - qmul(qconst(1, 5), qmul(uu, mom)));
    return c2 > 0;
  endfunction

  function automatic face_flux_t rusanov_flux(fix_t q[6]);
    face_flux_t r;
    longint ql[3];
    longint qr[3];
    longint fa[3];
    longint fb[3];
    longint sa;
    longint sb;
    longint hs;
    bit     oka;
    bit     okb;
    for (int k = 0; k < 3; k++) begin
      ql[k] = longint'(q[k]);
      qr[k] = longint'(q[k+3]);
      r.flux[k] = '0;
    end
    if (ql[0] <= 0 || qr[0] <= 0) begin
      r.status = ST_BAD_RHO;
      return r;
    end
    oka = side_eval(ql[0], ql[1], ql[2], sa, fa);
    okb = side_eval(qr[0], qr[1], qr[2], sb, fb);
    if (!oka || !okb) begin
      r.status = ST_BAD_C2;
      return r;
    end
    hs = qmul(qconst(1, 2), sa > sb ? sa : sb);
    for (int k = 0; k < 3; k++) begin
      r.flux[k] = fix_t'(sat(sat(qmul(qconst(1, 2), fa[k]) + qmul(qconst(1, 2), fb[k]))
                             - qmul(hs, sat(qr[k] - ql[k]))));
    end
    r.status = ST_OK;
    return r;
  endfunction

  task automatic add_row(longint a, longint b, longint c, longint d, longint e, longint f,
                         bit typed = 1'b0, erf_status_e st = ST_OK);
    face_row_t r;
    r.q[0] = fix_t'(a); r.q[1] = fix_t'(b); r.q[2] = fix_t'(c);
    r.q[3] = fix_t'(d); r.q[4] = fix_t'(e); r.q[5] = fix_t'(f);
    r.typed  = typed;
    r.status = st;
    rows.push_back(r);
  endtask

  task automatic send_face(fix_t q[6]);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q[5], q[4], q[3], q[2], q[1], q[0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Mostly physical states: positive density, energy above the kinetic part.
  function automatic void random_face(ref fix_t q[6]);
    longint rho;
    longint u;
    for (int s = 0; s < 2; s++) begin
      if ($urandom_range(9) < 2) begin
        for (int k = 0; k < 3; k++) q[3*s+k] = $urandom;
      end else begin
        rho = $urandom_range(3) == 0 ? longint'($urandom_range(1, 32'h7fffffff))
                                     : longint'($urandom_range(32'h400, 32'h80000));
        u   = longint'($urandom_range(0, 32'h60000)) - 32'h30000;
        q[3*s]   = fix_t'(sat(qmul(rho, u)));
        q[3*s+2] = fix_t'(sat(qmul(rho, qmul(u, u) / 2 + $urandom_range(32'h100, 32'h40000))));
        q[3*s+1] = $urandom_range(15) == 0 ? fix_t'($urandom) : q[3*s];
        q[3*s]   = fix_t'(rho);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= $urandom_range(99) >= recv_idle;
  end

  always @(posedge clk_i) begin
    face_flux_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (flux_q.size() == 0) begin
        $error("unexpected word: tdata=%h tuser=%0d", m_axis_tdata, m_axis_tuser);
        fails++;
      end else begin
        want = flux_q.pop_front();
        if (m_axis_tdata[31:0] !== want.flux[0]) begin
          $error("mass_flux: expected %h, got %h", want.flux[0], m_axis_tdata[31:0]);
          fails++;
        end
        if (m_axis_tdata[63:32] !== want.flux[1]) begin
          $error("momentum_flux: expected %h, got %h", want.flux[1], m_axis_tdata[63:32]);
          fails++;
        end
        if (m_axis_tdata[95:64] !== want.flux[2]) begin
          $error("energy_flux: expected %h, got %h", want.flux[2], m_axis_tdata[95:64]);
          fails++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    fix_t       q[6];
    face_flux_t want;
    add_row(0, 0, 0, ONE, 0, ONE, 1'b1, ST_BAD_RHO);
    add_row(ONE, 0, ONE, VMIN, VMAX, VMIN, 1'b1, ST_BAD_RHO);
    add_row(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 1'b1, ST_BAD_RHO);
    add_row(ONE, 0, 0, ONE, 0, 2 * ONE, 1'b1, ST_BAD_C2);
    add_row(ONE, 0, VMIN, ONE, 0, ONE, 1'b1, ST_BAD_C2);
    add_row(ONE, 4 * ONE, ONE, ONE, 0, ONE, 1'b1, ST_BAD_C2);
    add_row(ONE, 0, 5 * ONE / 2, ONE / 8, 0, ONE / 4);
    add_row(ONE, ONE, 3 * ONE, ONE, -ONE, 3 * ONE);
    add_row(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
    add_row(1, 0, VMAX, 1, 0, VMAX);
    add_row(1, 1, VMAX, VMAX, VMIN, VMAX);
    add_row(ONE, VMAX, VMAX, ONE, VMIN, VMAX);
    add_row(1, VMIN, VMAX, 1, VMAX, VMAX);
    add_row(VMAX, 0, 1, VMAX, 0, 1);
    add_row(ONE, 0, ONE, ONE, 0, ONE);
    add_row(2 * ONE, -3 * ONE, 20 * ONE, ONE / 2, ONE, 4 * ONE);
    add_row(32'h12345, 32'h6789, 32'h7abcd, 32'h55555, -32'h2468, 32'h3cccc);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 20;
    recv_idle = 65;
    foreach (rows[i]) begin
      want = rusanov_flux(rows[i].q);
      if (rows[i].typed) begin
        want.status = rows[i].status;
        for (int k = 0; k < 3; k++) want.flux[k] = '0;
      end
      send_face(rows[i].q);
      flux_q.push_back(want);
    end

    for (int n = 0; n < NRAND; n++) begin
      if (n == NRAND / 3) begin
        send_idle = 65;
        recv_idle = 20;
      end else if (n == 2 * NRAND / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_face(q);
      send_face(q);
      flux_q.push_back(rusanov_flux(q));
    end
    s_axis_tvalid <= 1'b0;

    while (flux_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/erf_pkg.sv
sv/erf_delay.sv
sv/erf_qmul.sv
sv/erf_div.sv
sv/erf_sqrt.sv
sv/erf_side.sv
sv/euler_rusanov_flux_1d_top.sv
tb/tb_euler_rusanov_flux_1d_top.sv
